// File: src/crcbsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcbsf_pkg: shared constants and functions for the CRC-8 byte stuffing framer
// Line codes, CRC-8 parameters and the per-byte CRC update.
// ----------------------------------------------------------------------------
package crcbsf_pkg;

  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
  localparam logic [7:0] ESCAPE_XOR  = 8'h20;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] CRC_XOROUT  = 8'h55;

  // Longest line sequence caused by one input item.
  localparam int unsigned MaxSeq = 6;
  localparam int unsigned SeqW   = $clog2(MaxSeq + 1);

  typedef struct packed {
    logic       done;
    logic [7:0] data;
  } line_entry_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESCAPE_BYTE);
  endfunction

endpackage

// File: src/crc8_byte_stuffing_framer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_byte_stuffing_framer_top: HDLC-style framer with CRC-8 trailer
// Wraps payload bytes in flags, escapes 0x7E/0x7D and appends a stuffed CRC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one raw payload byte per item, with
//   in_end_of_payload set on the final byte of a frame. The first byte after
//   reset or after a closed frame opens a new frame.
//   Output channel (out_valid / out_stall): one line byte per item; opening
//   flag, data or escape pairs, stuffed CRC-8 (poly 0x07, init 0, xorout
//   0x55), and the closing flag, which carries out_frame_done.
//   Path: an accepted item is held in the input register, then loaded into
//   the sequence register, from which its line bytes are sent.
//   Throughput: one line byte per cycle while out_stall is low; an input
//   item causes 1 to 6 line bytes. The next item waits in the input
//   register and is loaded in the cycle the last byte of the current
//   sequence is taken.
//   Reset: clears both registers' valid state, the frame state and the CRC.
//   Stall: while out_stall is high the current byte holds; once the input
//   register is also full, in_stall rises.
// ----------------------------------------------------------------------------
module crc8_byte_stuffing_framer_top
  import crcbsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_payload,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_line_byte,
  output logic       out_frame_done
);

  logic              in_vld_r;
  logic [7:0]        in_byte_r;
  logic              in_last_r;
  logic              inside_r, inside_nxt;
  logic [7:0]        crc_r, crc_nxt;
  logic [SeqW-1:0]   cnt_r, cnt_nxt;
  logic [SeqW-1:0]   idx_r, idx_nxt;
  line_entry_t       seq_r [MaxSeq];
  line_entry_t       seq_nxt [MaxSeq];
  logic [SeqW-1:0]   seq_cnt;
  logic [7:0]        crc_upd;
  logic [7:0]        crc_fin;
  logic              out_take;
  logic              last_going;
  logic              load;

  assign out_valid      = (cnt_r != '0);
  assign out_line_byte  = seq_r[idx_r].data;
  assign out_frame_done = seq_r[idx_r].done;

  assign out_take   = out_valid && !out_stall;
  assign last_going = out_take && (idx_r == cnt_r - SeqW'(1));
  assign load       = in_vld_r && (!out_valid || last_going);
  assign in_stall   = in_vld_r && !load;

  assign crc_upd = crc8_update(inside_r ? crc_r : 8'h00, in_byte_r);
  assign crc_fin = crc_upd ^ CRC_XOROUT;

  always_comb begin
    logic [SeqW-1:0] n;
    n = '0;
    for (int i = 0; i < MaxSeq; i++) begin
      seq_nxt[i] = '{done: 1'b0, data: FLAG_BYTE};
    end
    if (!inside_r) begin
      seq_nxt[n] = '{done: 1'b0, data: FLAG_BYTE};
      n = n + SeqW'(1);
    end
    if (needs_escape(in_byte_r)) begin
      seq_nxt[n] = '{done: 1'b0, data: ESCAPE_BYTE};
      n = n + SeqW'(1);
      seq_nxt[n] = '{done: 1'b0, data: in_byte_r ^ ESCAPE_XOR};
    end else begin
      seq_nxt[n] = '{done: 1'b0, data: in_byte_r};
    end
    n = n + SeqW'(1);
    if (in_last_r) begin
      if (needs_escape(crc_fin)) begin
        seq_nxt[n] = '{done: 1'b0, data: ESCAPE_BYTE};
        n = n + SeqW'(1);
        seq_nxt[n] = '{done: 1'b0, data: crc_fin ^ ESCAPE_XOR};
      end else begin
        seq_nxt[n] = '{done: 1'b0, data: crc_fin};
      end
      n = n + SeqW'(1);
      seq_nxt[n] = '{done: 1'b1, data: FLAG_BYTE};
      n = n + SeqW'(1);
    end
    seq_cnt = n;
  end

  always_comb begin
    inside_nxt = inside_r;
    crc_nxt    = crc_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    if (out_take) begin
      if (last_going) begin
        cnt_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + SeqW'(1);
      end
    end
    if (load) begin
      cnt_nxt    = seq_cnt;
      idx_nxt    = '0;
      inside_nxt = !in_last_r;
      crc_nxt    = in_last_r ? 8'h00 : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      inside_r <= 1'b0;
      crc_r    <= 8'h00;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      inside_r <= inside_nxt;
      crc_r    <= crc_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (load) begin
        in_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_end_of_payload;
    end
    if (load) begin
      seq_r <= seq_nxt;
    end
  end

endmodule

// File: src/crcbsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcbsf_checker: port-level assertions for the framer
// Watches both channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module crcbsf_checker
  import crcbsf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_data_byte,
  input logic       in_end_of_payload,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_line_byte,
  input logic       out_frame_done
);

  a_done_is_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_line_byte == FLAG_BYTE)
    else $error("frame_done on a byte other than the closing flag");

  a_accept_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> ##1 out_valid)
    else $error("accepted item did not reach the output in two cycles");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_byte_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_line_byte) && $stable(out_frame_done))
    else $error("output item changed while stalled");

  a_in_item_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte) &&
                             $stable(in_end_of_payload))
    else $error("input item changed while stalled");

endmodule

bind crc8_byte_stuffing_framer_top crcbsf_checker u_crcbsf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_data_byte      (in_data_byte),
  .in_end_of_payload (in_end_of_payload),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_line_byte     (out_line_byte),
  .out_frame_done    (out_frame_done)
);

// File: tb/crc8_byte_stuffing_framer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_byte_stuffing_framer_top_tb: self-checking bench for the CRC-8 framer
// Sends payload bytes in frames, predicts the flagged, escaped line stream
// with its CRC-8 trailer, and compares every line byte as it leaves the block.
// Both channels idle at random; one phase holds the line side for a long time.
// ----------------------------------------------------------------------------
module crc8_byte_stuffing_framer_top_tb;
  import crcbsf_pkg::*;

  localparam int unsigned ClkPeriod  = 12;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned LongHold   = 60;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned LimitCycles = 500_000;
  localparam int unsigned MaxReports = 10;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_end_of_payload;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_line_byte;
  logic       out_frame_done;

  line_entry_t pending_line[$];
  line_entry_t want;
  logic        frame_open;
  logic [7:0]  crc_acc;
  int unsigned err_count;
  bit          idle_en;
  bit          long_hold_req;
  int unsigned rx_hold;
  int unsigned rx_free;

  crc8_byte_stuffing_framer_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_payload (in_end_of_payload),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_byte     (out_line_byte),
    .out_frame_done    (out_frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2.0) clk = ~clk;
  end

  initial begin
    repeat (LimitCycles) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  // Bit-serial CRC-8, MSB first, poly 0x07.
  function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic void push_line(input logic [7:0] b, input logic done);
    line_entry_t e;
    e.data = b;
    e.done = done;
    pending_line.push_back(e);
  endfunction

  function automatic void push_stuffed(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESCAPE_BYTE) begin
      push_line(ESCAPE_BYTE, 1'b0);
      push_line(b ^ ESCAPE_XOR, 1'b0);
    end else begin
      push_line(b, 1'b0);
    end
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic eop);
    if (!frame_open) begin
      push_line(FLAG_BYTE, 1'b0);
      frame_open = 1'b1;
      crc_acc    = 8'h00;
    end
    push_stuffed(b);
    crc_acc = crc8_shift(crc_acc, b);
    if (eop) begin
      push_stuffed(crc_acc ^ CRC_XOROUT);
      push_line(FLAG_BYTE, 1'b1);
      frame_open = 1'b0;
      crc_acc    = 8'h00;
    end
  endfunction

  // Payload byte that makes the trailer of a single-byte frame equal target.
  function automatic logic [7:0] byte_for_trailer(input logic [7:0] target);
    logic [7:0] hit;
    hit = 8'h00;
    for (int b = 0; b < 256; b++)
      if ((crc8_shift(8'h00, b[7:0]) ^ CRC_XOROUT) == target) hit = b[7:0];
    return hit;
  endfunction

  // Lead byte of a two-byte frame ending in last whose trailer equals target.
  function automatic logic [7:0] lead_for_trailer(input logic [7:0] last,
                                                  input logic [7:0] target);
    logic [7:0] hit;
    hit = 8'h00;
    for (int p = 0; p < 256; p++)
      if ((crc8_shift(crc8_shift(8'h00, p[7:0]), last) ^ CRC_XOROUT) == target)
        hit = p[7:0];
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 99) >= 25) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       return FLAG_BYTE;
      1:       return ESCAPE_BYTE;
      2:       return FLAG_BYTE ^ ESCAPE_XOR;
      3:       return ESCAPE_BYTE ^ ESCAPE_XOR;
      4:       return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic int unsigned pick_frame_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eop);
    int unsigned gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_end_of_payload <= eop;
    do @(posedge clk); while (in_stall);
    encode_byte(b, eop);
  endtask

  task automatic send_random_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_byte(pick_byte(), i == len - 1);
  endtask

  task automatic wait_line_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_line.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Line side: random stalls, plus a long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    rx_hold = 0;
    rx_free = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_hold = LongHold;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (!idle_en || rx_free != 0) begin
        if (rx_free != 0) rx_free--;
        out_stall <= 1'b0;
      end else begin
        rx_hold = ($urandom_range(0, 99) < 35) ? pick_gap() : 0;
        rx_free = $urandom_range(1, 8);
        out_stall <= (rx_hold != 0);
        if (rx_hold != 0) rx_hold--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line byte checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_line.size() == 0) begin
        if (err_count < MaxReports)
          $display("%0t: unexpected line item %02h done %0b", $realtime,
                   out_line_byte, out_frame_done);
        err_count++;
      end else begin
        want = pending_line.pop_front();
        if (out_line_byte !== want.data || out_frame_done !== want.done) begin
          if (err_count < MaxReports)
            $display("%0t: line_byte exp %02h got %02h, frame_done exp %0b got %0b",
                     $realtime, want.data, out_line_byte, want.done, out_frame_done);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_single_byte_frames();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(FLAG_BYTE, 1'b1);
    send_byte(ESCAPE_BYTE, 1'b1);
    send_byte(FLAG_BYTE ^ ESCAPE_XOR, 1'b1);
    send_byte(ESCAPE_BYTE ^ ESCAPE_XOR, 1'b1);
    wait_line_idle();
  endtask

  task automatic test_escaped_payload();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(FLAG_BYTE, 1'b0);
    send_byte(ESCAPE_BYTE, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(FLAG_BYTE, 1'b1);
    wait_line_idle();
  endtask

  task automatic test_stuffed_crc();
    send_byte(byte_for_trailer(FLAG_BYTE), 1'b1);
    send_byte(byte_for_trailer(ESCAPE_BYTE), 1'b1);
    send_byte(lead_for_trailer(FLAG_BYTE, FLAG_BYTE), 1'b0);
    send_byte(FLAG_BYTE, 1'b1);
    send_byte(lead_for_trailer(ESCAPE_BYTE, ESCAPE_BYTE), 1'b0);
    send_byte(ESCAPE_BYTE, 1'b1);
    wait_line_idle();
  endtask

  task automatic test_random_frames(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = pick_frame_len();
      send_random_frame(len);
      sent += len;
    end
    wait_line_idle();
  endtask

  // Line side frozen while bytes keep coming: input backs up and stalls.
  task automatic test_long_output_hold();
    idle_en = 1'b0;
    long_hold_req = 1'b1;
    send_random_frame(3);
    send_random_frame(5);
    send_random_frame(8);
    wait_line_idle();
    idle_en = 1'b1;
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    test_random_frames(30);
    idle_en = 1'b1;
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_data_byte      <= 8'h00;
    in_end_of_payload <= 1'b0;
    frame_open    = 1'b0;
    crc_acc       = 8'h00;
    err_count     = 0;
    idle_en       = 1'b1;
    long_hold_req = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_byte_frames();
    test_escaped_payload();
    test_stuffed_crc();
    test_random_frames(300);
    test_long_output_hold();
    test_back_to_back();

    repeat (TailCycles) @(posedge clk);
    if (err_count == 0 && pending_line.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
src/crcbsf_pkg.sv
src/crc8_byte_stuffing_framer_top.sv
src/crcbsf_checker.sv
tb/crc8_byte_stuffing_framer_top_tb.sv
